// ===== sv/rsb_pkg.sv =====
// Shared types and constants of the rank/select bit vector.
// Holds memory geometry, request and status codes, and the memory port structs.
// Depends on nothing.
package rsb_pkg;

  localparam int MaxBits  = 65536;
  localparam int WordBits = 32;
  localparam int Words    = MaxBits / WordBits;
  localparam int Blocks   = MaxBits / 8 + 2;
  localparam int Supers   = MaxBits / 16 + 2;
  localparam int WordAw   = $clog2(Words);
  localparam int BlkAw    = $clog2(Blocks);
  localparam int SupAw    = $clog2(Supers);
  localparam int PosAw    = $clog2(MaxBits);
  localparam int IdxW     = 17;
  localparam int BlkW     = 18;

  typedef enum logic [2:0] {
    REQ_SET    = 3'd0,
    REQ_BUILD  = 3'd1,
    REQ_ACCESS = 3'd2,
    REQ_RANK   = 3'd3,
    REQ_SELECT = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_SEL      = 2'd2,
    ST_NO_BUILD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_BIT_COUNT  = 2'd0,
    CFG_BLOCK_LOG2 = 2'd1,
    CFG_SUPER_LOG2 = 2'd2
  } cfg_e;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [WordAw-1:0]   addr;
    logic [WordBits-1:0] wdata;
  } bit_req_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [BlkAw-1:0] addr;
    logic [BlkW-1:0]  wdata;
  } blk_req_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [SupAw-1:0] addr;
    logic [IdxW-1:0]  wdata;
  } sup_req_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [PosAw-1:0] addr;
    logic [7:0]       wdata;
  } pos_req_t;

endpackage

// ===== sv/rsb_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package dependency.
module rsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rsb_ctrl.sv =====
// Sequencer of the rank/select bit vector: config registers, build walk,
// query sequences, clearing sweep and the result register.
// Depends on rsb_pkg; drives the four memories through request structs.
module rsb_ctrl
  import rsb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          req_type_i,
  input  logic [IdxW-1:0]     query_index_i,
  input  logic                bit_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IdxW-1:0]     answer_o,
  output logic [1:0]          status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [IdxW-1:0]     cfg_data_i,
  output bit_req_t            bit_req_o,
  input  logic [WordBits-1:0] bit_rdata_i,
  output blk_req_t            blk_req_o,
  input  logic [BlkW-1:0]     blk_rdata_i,
  output sup_req_t            sup_req_o,
  input  logic [IdxW-1:0]     sup_rdata_i,
  output pos_req_t            pos_req_o,
  input  logic [7:0]          pos_rdata_i
);

  typedef enum logic [18:0] {
    S_INIT    = 19'h00001,
    S_IDLE    = 19'h00002,
    S_DONE    = 19'h00004,
    S_CLR     = 19'h00008,
    S_SET_RD  = 19'h00010,
    S_SET_WR  = 19'h00020,
    S_ACC_RD  = 19'h00040,
    S_ACC_BIT = 19'h00080,
    S_RK_RD0  = 19'h00100,
    S_RK_RD1  = 19'h00200,
    S_RK_END  = 19'h00400,
    S_RK_RD   = 19'h00800,
    S_RK_CMP  = 19'h01000,
    S_SL_CHK  = 19'h02000,
    S_SL_CMP  = 19'h04000,
    S_SL_POS  = 19'h08000,
    S_B_BLK   = 19'h10000,
    S_B_BIT   = 19'h20000,
    S_B_END   = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0]   bit_count_q, bit_count_d;
  logic [3:0]        block_log2_q, block_log2_d;
  logic [3:0]        super_log2_q, super_log2_d;
  logic              built_q, built_d;
  logic [IdxW-1:0]   total_q, total_d;
  logic [WordAw-1:0] sweep_q, sweep_d;

  logic [IdxW-1:0]   q_q, q_d;
  logic              v_q, v_d;
  logic [IdxW-1:0]   res_ans_q, res_ans_d;
  status_e           res_st_q, res_st_d;

  logic [BlkAw-1:0]  blk_q, blk_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [8:0]        j_q, j_d;
  logic [IdxW-1:0]   sup_q, sup_d;
  logic [IdxW-1:0]   brank_q, brank_d;
  logic              has_q, has_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   end_q, end_d;
  logic [BlkAw-1:0]  lo_q, lo_d;
  logic [BlkAw-1:0]  hi_q, hi_d;
  logic [BlkAw-1:0]  mid_q, mid_d;

  logic              out_valid_q, out_valid_d;
  logic [IdxW-1:0]   out_ans_q, out_ans_d;
  logic [1:0]        out_st_q, out_st_d;

  logic [IdxW-1:0]   n_eff;
  logic [3:0]        bl;
  logic [3:0]        sl;
  logic [8:0]        bsize;
  logic [BlkAw-1:0]  spb_mask;
  logic [BlkAw-1:0]  nblocks;
  logic [BlkAw-1:0]  q_blk;
  logic [BlkAw-1:0]  q_blk1;
  logic [7:0]        q_low;
  logic [IdxW-1:0]   tab_sum;
  logic [BlkAw-1:0]  mid_c;
  logic [BlkAw:0]    span;
  logic [IdxW-1:0]   blk_pos;
  logic [IdxW-1:0]   pos_n;
  logic [8:0]        j_n;
  logic              cur_bit;
  logic [IdxW-1:0]   sel_base;
  logic [IdxW-1:0]   k_m1;
  req_e              req;

  // Effective geometry: registers saturate to their legal ranges.
  assign n_eff    = (bit_count_q > IdxW'(MaxBits)) ? IdxW'(MaxBits) : bit_count_q;
  assign bl       = (block_log2_q < 4'd3) ? 4'd3 : ((block_log2_q > 4'd8) ? 4'd8 : block_log2_q);
  assign sl       = (super_log2_q < 4'd1) ? 4'd1 : ((super_log2_q > 4'd8) ? 4'd8 : super_log2_q);
  assign bsize    = 9'd1 << bl;
  assign spb_mask = BlkAw'((9'd1 << sl) - 9'd1);
  assign nblocks  = BlkAw'(({1'b0, n_eff} + {9'b0, bsize} - 18'd1) >> bl);
  assign q_blk    = BlkAw'(q_q >> bl);
  assign q_blk1   = q_blk + BlkAw'(1);
  assign q_low    = q_q[7:0] & 8'(bsize - 9'd1);
  assign tab_sum  = sup_rdata_i + blk_rdata_i[IdxW-1:0];
  assign span     = {1'b0, hi_q} - {1'b0, lo_q} + (BlkAw+1)'(1);
  assign mid_c    = lo_q + BlkAw'(span >> 1);
  assign blk_pos  = IdxW'({8'b0, blk_q} << bl);
  assign pos_n    = pos_q + IdxW'(1);
  assign j_n      = j_q + 9'd1;
  assign cur_bit  = bit_rdata_i[5'd31 - pos_q[4:0]];
  assign sel_base = IdxW'({8'b0, lo_q} << bl);
  assign k_m1     = q_q - IdxW'(1);
  assign req      = req_e'(req_type_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign answer_o    = out_ans_q;
  assign status_o    = out_st_q;

  always_comb begin
    state_d      = state_q;
    bit_count_d  = bit_count_q;
    block_log2_d = block_log2_q;
    super_log2_d = super_log2_q;
    built_d      = built_q;
    total_d      = total_q;
    sweep_d      = sweep_q;
    q_d          = q_q;
    v_d          = v_q;
    res_ans_d    = res_ans_q;
    res_st_d     = res_st_q;
    blk_d        = blk_q;
    pos_d        = pos_q;
    j_d          = j_q;
    sup_d        = sup_q;
    brank_d      = brank_q;
    has_d        = has_q;
    idx_d        = idx_q;
    end_d        = end_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_ans_d    = out_ans_q;
    out_st_d     = out_st_q;
    bit_req_o    = '0;
    blk_req_o    = '0;
    sup_req_o    = '0;
    pos_req_o    = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BIT_COUNT: begin
          bit_count_d = cfg_data_i;
          built_d     = 1'b0;
        end
        CFG_BLOCK_LOG2: begin
          block_log2_d = cfg_data_i[3:0];
          built_d      = 1'b0;
        end
        CFG_SUPER_LOG2: begin
          super_log2_d = cfg_data_i[3:0];
          built_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_INIT, S_CLR: begin
        bit_req_o.we   = 1'b1;
        bit_req_o.addr = sweep_q;
        sweep_d        = sweep_q + WordAw'(1);
        if (sweep_q == WordAw'(Words - 1)) begin
          state_d = (state_q == S_CLR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          q_d       = query_index_i;
          v_d       = bit_value_i;
          res_ans_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_DONE;
          unique case (req)
            REQ_SET: begin
              if (query_index_i >= n_eff) begin
                res_st_d = ST_RANGE;
              end else begin
                state_d = S_SET_RD;
              end
            end
            REQ_BUILD: begin
              blk_d   = '0;
              total_d = '0;
              sup_d   = '0;
              state_d = S_B_BLK;
            end
            REQ_ACCESS, REQ_RANK: begin
              if (!built_q) begin
                res_st_d = ST_NO_BUILD;
              end else if (query_index_i >= n_eff) begin
                res_st_d = ST_RANGE;
              end else begin
                state_d = (req == REQ_ACCESS) ? S_ACC_RD : S_RK_RD0;
              end
            end
            REQ_SELECT: begin
              if (!built_q) begin
                res_st_d = ST_NO_BUILD;
              end else if (query_index_i == '0 || query_index_i > total_q) begin
                res_st_d = ST_SEL;
              end else begin
                lo_d    = '0;
                hi_d    = (nblocks == '0) ? '0 : nblocks - BlkAw'(1);
                state_d = S_SL_CHK;
              end
            end
            REQ_CLEAR: begin
              total_d = '0;
              built_d = 1'b0;
              sweep_d = '0;
              state_d = S_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ans_d   = res_ans_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      S_SET_RD: begin
        bit_req_o.re   = 1'b1;
        bit_req_o.addr = q_q[PosAw-1:5];
        state_d        = S_SET_WR;
      end
      S_SET_WR: begin
        bit_req_o.we    = 1'b1;
        bit_req_o.addr  = q_q[PosAw-1:5];
        bit_req_o.wdata = bit_rdata_i | ({31'b0, v_q} << (5'd31 - q_q[4:0]));
        built_d         = 1'b0;
        state_d         = S_DONE;
      end
      S_ACC_RD: begin
        bit_req_o.re   = 1'b1;
        bit_req_o.addr = q_q[PosAw-1:5];
        state_d        = S_ACC_BIT;
      end
      S_ACC_BIT: begin
        res_ans_d = {16'b0, bit_rdata_i[5'd31 - q_q[4:0]]};
        state_d   = S_DONE;
      end
      S_RK_RD0: begin
        sup_req_o.re   = 1'b1;
        sup_req_o.addr = SupAw'(q_blk >> sl);
        blk_req_o.re   = 1'b1;
        blk_req_o.addr = q_blk;
        state_d        = S_RK_RD1;
      end
      S_RK_RD1: begin
        idx_d = tab_sum;
        if (!blk_rdata_i[BlkW-1]) begin
          res_ans_d = tab_sum;
          state_d   = S_DONE;
        end else begin
          sup_req_o.re   = 1'b1;
          sup_req_o.addr = SupAw'(q_blk1 >> sl);
          blk_req_o.re   = 1'b1;
          blk_req_o.addr = q_blk1;
          state_d        = S_RK_END;
        end
      end
      S_RK_END: begin
        end_d   = tab_sum;
        state_d = S_RK_RD;
      end
      S_RK_RD: begin
        if (idx_q >= end_q) begin
          res_ans_d = idx_q;
          state_d   = S_DONE;
        end else begin
          pos_req_o.re   = 1'b1;
          pos_req_o.addr = idx_q[PosAw-1:0];
          state_d        = S_RK_CMP;
        end
      end
      S_RK_CMP: begin
        if (pos_rdata_i > q_low) begin
          res_ans_d = idx_q;
          state_d   = S_DONE;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_RK_RD;
        end
      end
      S_SL_CHK: begin
        if (lo_q < hi_q) begin
          mid_d          = mid_c;
          sup_req_o.re   = 1'b1;
          sup_req_o.addr = SupAw'(mid_c >> sl);
          blk_req_o.re   = 1'b1;
          blk_req_o.addr = mid_c;
          state_d        = S_SL_CMP;
        end else begin
          pos_req_o.re   = 1'b1;
          pos_req_o.addr = k_m1[PosAw-1:0];
          state_d        = S_SL_POS;
        end
      end
      S_SL_CMP: begin
        if (tab_sum < q_q) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q - BlkAw'(1);
        end
        state_d = S_SL_CHK;
      end
      S_SL_POS: begin
        res_ans_d = sel_base + {9'b0, pos_rdata_i};
        state_d   = S_DONE;
      end
      S_B_BLK: begin
        if ((blk_q & spb_mask) == '0) begin
          sup_req_o.we    = 1'b1;
          sup_req_o.addr  = SupAw'(blk_q >> sl);
          sup_req_o.wdata = total_q;
          sup_d           = total_q;
          brank_d         = '0;
        end else begin
          brank_d = total_q - sup_q;
        end
        has_d = 1'b0;
        j_d   = '0;
        pos_d = blk_pos;
        if (blk_pos < n_eff) begin
          bit_req_o.re   = 1'b1;
          bit_req_o.addr = blk_pos[PosAw-1:5];
          state_d        = S_B_BIT;
        end else begin
          state_d = S_B_END;
        end
      end
      S_B_BIT: begin
        if (cur_bit) begin
          pos_req_o.we    = 1'b1;
          pos_req_o.addr  = total_q[PosAw-1:0];
          pos_req_o.wdata = j_q[7:0];
          total_d         = total_q + IdxW'(1);
          has_d           = 1'b1;
        end
        pos_d = pos_n;
        j_d   = j_n;
        if (j_n == bsize || pos_n >= n_eff) begin
          state_d = S_B_END;
        end else if (pos_n[4:0] == 5'd0) begin
          bit_req_o.re   = 1'b1;
          bit_req_o.addr = pos_n[PosAw-1:5];
        end
      end
      S_B_END: begin
        blk_req_o.we    = 1'b1;
        blk_req_o.addr  = blk_q;
        blk_req_o.wdata = {has_q, brank_q};
        if (blk_q == nblocks) begin
          built_d   = 1'b1;
          res_ans_d = total_q;
          state_d   = S_DONE;
        end else begin
          blk_d   = blk_q + BlkAw'(1);
          state_d = S_B_BLK;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      bit_count_q  <= '0;
      block_log2_q <= 4'd5;
      super_log2_q <= 4'd4;
      built_q      <= 1'b0;
      total_q      <= '0;
      sweep_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_count_q  <= bit_count_d;
      block_log2_q <= block_log2_d;
      super_log2_q <= super_log2_d;
      built_q      <= built_d;
      total_q      <= total_d;
      sweep_q      <= sweep_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    v_q       <= v_d;
    res_ans_q <= res_ans_d;
    res_st_q  <= res_st_d;
    blk_q     <= blk_d;
    pos_q     <= pos_d;
    j_q       <= j_d;
    sup_q     <= sup_d;
    brank_q   <= brank_d;
    has_q     <= has_d;
    idx_q     <= idx_d;
    end_q     <= end_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    out_ans_q <= out_ans_d;
    out_st_q  <= out_st_d;
  end

endmodule

// ===== sv/rank_select_bitvector_top.sv =====
// Top level of the rank/select bit vector: sequencer plus four memories.
// Depends on rsb_pkg, rsb_ram and rsb_ctrl.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | req_type_i, query_index_i, bit_value_i
//   out     | output    | out_valid_o / out_stall_i | answer_o, status_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time. Errors go straight to the result; rank reads the tables and,
// if the queried block holds a one, steps through its ones; select halves the block range.
// Build walks every valid bit (one per cycle) and ends each block with a table write.
// Clear and reset both run a sweep over every word of the bit memory; requests stall
// meanwhile, config writes are taken. A result waits in the output register while
// out_stall_i is high; a finished request holds in its last state until that
// register is free, so the next request can be taken while one result waits.
module rank_select_bitvector_top
  import rsb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      req_type_i,
  input  logic [IdxW-1:0] query_index_i,
  input  logic            bit_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] answer_o,
  output logic [1:0]      status_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [IdxW-1:0] cfg_data_i
);

  bit_req_t            bit_req;
  blk_req_t            blk_req;
  sup_req_t            sup_req;
  pos_req_t            pos_req;
  logic [WordBits-1:0] bit_rdata;
  logic [BlkW-1:0]     blk_rdata;
  logic [IdxW-1:0]     sup_rdata;
  logic [7:0]          pos_rdata;

  // Sequencer: owns all control state and the result register.
  rsb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .query_index_i,
    .bit_value_i,
    .out_valid_o,
    .out_stall_i,
    .answer_o,
    .status_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .bit_req_o   (bit_req),
    .bit_rdata_i (bit_rdata),
    .blk_req_o   (blk_req),
    .blk_rdata_i (blk_rdata),
    .sup_req_o   (sup_req),
    .sup_rdata_i (sup_rdata),
    .pos_req_o   (pos_req),
    .pos_rdata_i (pos_rdata)
  );

  // Bit vector words, MSB first within a word.
  rsb_ram #(.Width(WordBits), .Depth(Words)) u_bit_ram (
    .clk_i,
    .we_i    (bit_req.we),
    .re_i    (bit_req.re),
    .addr_i  (bit_req.addr),
    .wdata_i (bit_req.wdata),
    .rdata_o (bit_rdata)
  );

  // Per block: has-one flag on top of the rank within its superblock.
  rsb_ram #(.Width(BlkW), .Depth(Blocks)) u_blk_ram (
    .clk_i,
    .we_i    (blk_req.we),
    .re_i    (blk_req.re),
    .addr_i  (blk_req.addr),
    .wdata_i (blk_req.wdata),
    .rdata_o (blk_rdata)
  );

  // Absolute rank at the start of every superblock.
  rsb_ram #(.Width(IdxW), .Depth(Supers)) u_sup_ram (
    .clk_i,
    .we_i    (sup_req.we),
    .re_i    (sup_req.re),
    .addr_i  (sup_req.addr),
    .wdata_i (sup_req.wdata),
    .rdata_o (sup_rdata)
  );

  // In-block offset of every one, in order.
  rsb_ram #(.Width(8), .Depth(MaxBits)) u_pos_ram (
    .clk_i,
    .we_i    (pos_req.we),
    .re_i    (pos_req.re),
    .addr_i  (pos_req.addr),
    .wdata_i (pos_req.wdata),
    .rdata_o (pos_rdata)
  );

endmodule
